// ===== hdl/c3s2r_pkg.sv =====
// shared constants, types and the fp32 round-and-pack function for the
// 3x3 stride-2 relu convolution block; no dependencies
package c3s2r_pkg;

   localparam int DEF_IMAGE_HEIGHT = 28;
   localparam int DEF_IMAGE_WIDTH  = 28;
   localparam int DEF_IN_CHANNELS  = 1;
   localparam int DEF_OUT_CHANNELS = 4;

   localparam int KERNEL_SIZE = 3;
   localparam int TAPS        = KERNEL_SIZE * KERNEL_SIZE;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   localparam logic ACT_WEIGHT = 1'b0;
   localparam logic ACT_PIXEL  = 1'b1;

   localparam logic [31:0] FP32_QNAN = 32'h7FC0_0000;
   localparam logic [31:0] FP32_INF  = 32'h7F80_0000;

   // value = sig * 2^expo, sign apart
   typedef struct packed {
      logic               sign;
      logic signed [10:0] expo;
      logic [27:0]        sig;
   } raw_fp_type;

   // round to nearest even into fp32, subnormals and overflow included
   function automatic logic [31:0] round_pack(input raw_fp_type v);
      logic [4:0]         msb;
      logic signed [12:0] r_norm;
      logic signed [12:0] r_sub;
      logic signed [12:0] r;
      logic [4:0]         rc;
      logic [57:0]        ext;
      logic [24:0]        q;
      logic               grd;
      logic               stk;
      logic signed [12:0] biased;
      logic [39:0]        total;
      logic [31:0]        res;
      msb = '0;
      for (int i = 0; i < 28; i++) begin
         if (v.sig[i]) msb = 5'(i);
      end
      r_norm = $signed({8'b0, msb}) - 13'sd23;
      r_sub  = -13'sd149 - 13'(v.expo);
      r      = (r_norm > r_sub) ? r_norm : r_sub;
      ext    = '0;
      grd    = 1'b0;
      stk    = 1'b0;
      rc     = '0;
      if (r < 0) begin
         q = 25'(v.sig << 5'(-r));
      end else begin
         rc  = (r > 13'sd30) ? 5'd30 : 5'(r);
         ext = {v.sig, 30'b0} >> rc;
         q   = 25'(ext[57:30]);
         grd = ext[29];
         stk = |ext[28:0];
         if (grd && (stk || q[0])) q = q + 25'd1;
      end
      biased = 13'(v.expo) + r + 13'sd149;
      total  = (40'(biased) << 23) + 40'(q);
      if (v.sig == '0) begin
         res = '0;
      end else if (total >= 40'(FP32_INF)) begin
         res = {v.sign, FP32_INF[30:0]};
      end else begin
         res = {v.sign, total[30:0]};
      end
      return res;
   endfunction

endpackage

// ===== hdl/conv3x3_stride2_relu_bf16_top.sv =====
// top level of the 3x3 stride-2 zero-padded convolution with relu on bf16
// depends on c3s2r_pkg for constants, the raw float type and round_pack
//
// A weight beat (tuser 0) writes one weight slot; slots beyond the store are
// dropped. A pixel beat (tuser 1) is written into the row ring; the last
// channel of an odd row and odd column (or of the last row or column)
// starts one output pixel: for each output channel the block walks the
// 9*IN_CHANNELS taps through one shared float multiply-accumulate, in the
// fetch, multiply, pack, add and pack states for a tap inside the image and
// in the fetch state alone for a padded tap, then hands the bf16 result to
// the output register. Input is not taken meanwhile, but it is taken again
// while the last result of a pixel still waits on rsp_tready.
module conv3x3_stride2_relu_bf16_top #(
   parameter int IMAGE_HEIGHT = c3s2r_pkg::DEF_IMAGE_HEIGHT,
   parameter int IMAGE_WIDTH  = c3s2r_pkg::DEF_IMAGE_WIDTH,
   parameter int IN_CHANNELS  = c3s2r_pkg::DEF_IN_CHANNELS,
   parameter int OUT_CHANNELS = c3s2r_pkg::DEF_OUT_CHANNELS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // weight_index [5:0], sample [21:6], zero [23:22]
   input  logic [c3s2r_pkg::REQ_DATA_W-1:0] req_tdata,
   // action
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // result_value [15:0], out_channel [17:16], zero [23:18]
   output logic [c3s2r_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                             rsp_tlast,
   // last_of_image
   output logic                             rsp_tuser
);
   import c3s2r_pkg::*;

   localparam int W_DEPTH = OUT_CHANNELS * TAPS * IN_CHANNELS;
   localparam int R_DEPTH = KERNEL_SIZE * IMAGE_WIDTH * IN_CHANNELS;
   localparam int WA_W    = $clog2(W_DEPTH);
   localparam int RA_W    = $clog2(R_DEPTH);
   localparam int YW      = $clog2(IMAGE_HEIGHT);
   localparam int XW      = $clog2(IMAGE_WIDTH);
   localparam int CW      = (IN_CHANNELS > 1) ? $clog2(IN_CHANNELS) : 1;
   localparam int OW      = (OUT_CHANNELS > 1) ? $clog2(OUT_CHANNELS) : 1;
   localparam int YS      = YW + 2;
   localparam int XS      = XW + 2;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_FETCH = 3'd1;
   localparam logic [2:0] S_MUL   = 3'd2;
   localparam logic [2:0] S_PACKM = 3'd3;
   localparam logic [2:0] S_ADD   = 3'd4;
   localparam logic [2:0] S_PACKA = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   logic [15:0] weight_mem [W_DEPTH];
   logic [15:0] ring_mem [R_DEPTH];

   logic [2:0]           state_ff, state_in;
   logic [YW-1:0]        y_ff, y_in;
   logic [XW-1:0]        x_ff, x_in;
   logic [CW-1:0]        c_ff, c_in;
   logic [1:0]           slot_ff, slot_in;
   logic signed [YS-1:0] top_row_ff, top_row_in;
   logic signed [XS-1:0] left_col_ff, left_col_in;
   logic [1:0]           top_slot_ff, top_slot_in;
   logic                 image_end_ff, image_end_in;
   logic [OW-1:0]        oc_ff, oc_in;
   logic [1:0]           ky_ff, ky_in;
   logic [1:0]           kx_ff, kx_in;
   logic [CW-1:0]        ic_ff, ic_in;
   logic [WA_W-1:0]      w_addr_ff, w_addr_in;
   logic [15:0]          w_rd_ff;
   logic [15:0]          x_rd_ff;
   raw_fp_type           raw_ff, raw_in;
   logic                 spec_ff, spec_in;
   logic [31:0]          spec_bits_ff, spec_bits_in;
   logic [31:0]          prod_ff, prod_in;
   logic [31:0]          acc_ff, acc_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [15:0]          rsp_value_ff, rsp_value_in;
   logic [1:0]           rsp_oc_ff, rsp_oc_in;
   logic                 rsp_lastp_ff, rsp_lastp_in;
   logic                 rsp_lasti_ff, rsp_lasti_in;

   logic                 req_fire;
   logic [5:0]           req_index;
   logic [15:0]          req_sample;
   logic [RA_W-1:0]      ring_wr_addr;
   logic [RA_W-1:0]      ring_rd_addr;
   logic signed [YS-1:0] tap_row;
   logic signed [XS-1:0] tap_col;
   logic [2:0]           tap_slot_sum;
   logic [1:0]           tap_slot;
   logic                 tap_pad;
   logic                 tap_last;
   logic [31:0]          pack_out;
   raw_fp_type           mul_raw;
   logic                 mul_spec;
   logic [31:0]          mul_spec_bits;
   raw_fp_type           add_raw;
   logic                 add_spec;
   logic [31:0]          add_spec_bits;
   logic [15:0]          relu_value;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_index  = req_tdata[5:0];
   assign req_sample = req_tdata[21:6];

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_oc_ff, rsp_value_ff};
   assign rsp_tlast  = rsp_lastp_ff;
   assign rsp_tuser  = rsp_lasti_ff;

   // tap geometry
   always_comb begin
      tap_row      = top_row_ff + $signed(YS'(ky_ff));
      tap_col      = left_col_ff + $signed(XS'(kx_ff));
      tap_pad      = (tap_row < 0) || (tap_row >= $signed(YS'(IMAGE_HEIGHT))) ||
                     (tap_col < 0) || (tap_col >= $signed(XS'(IMAGE_WIDTH)));
      tap_slot_sum = {1'b0, top_slot_ff} + {1'b0, ky_ff};
      tap_slot     = (tap_slot_sum >= 3'd3) ? 2'(tap_slot_sum - 3'd3) : tap_slot_sum[1:0];
      ring_rd_addr = tap_pad ? '0 :
                     RA_W'((int'(tap_slot) * IMAGE_WIDTH + int'(tap_col[XW-1:0]))
                           * IN_CHANNELS + int'(ic_ff));
      ring_wr_addr = RA_W'((int'(slot_ff) * IMAGE_WIDTH + int'(x_ff)) * IN_CHANNELS
                           + int'(c_ff));
      tap_last     = (ic_ff == CW'(IN_CHANNELS - 1)) && (kx_ff == 2'd2) && (ky_ff == 2'd2);
   end

   // bf16 by bf16 product, exact before packing
   always_comb begin
      logic [7:0]         xe8, we8;
      logic               xnan, wnan, xinf, winf, xzero, wzero;
      logic [7:0]         xm, wm;
      logic signed [10:0] xe, we;
      xe8   = x_rd_ff[14:7];
      we8   = w_rd_ff[14:7];
      xnan  = (xe8 == 8'hFF) && (x_rd_ff[6:0] != '0);
      wnan  = (we8 == 8'hFF) && (w_rd_ff[6:0] != '0);
      xinf  = (xe8 == 8'hFF) && (x_rd_ff[6:0] == '0);
      winf  = (we8 == 8'hFF) && (w_rd_ff[6:0] == '0);
      xzero = (x_rd_ff[14:0] == '0);
      wzero = (w_rd_ff[14:0] == '0);
      xm    = {xe8 != '0, x_rd_ff[6:0]};
      wm    = {we8 != '0, w_rd_ff[6:0]};
      xe    = $signed({3'b0, (xe8 == '0) ? 8'd1 : xe8}) - 11'sd134;
      we    = $signed({3'b0, (we8 == '0) ? 8'd1 : we8}) - 11'sd134;
      mul_raw.sign = x_rd_ff[15] ^ w_rd_ff[15];
      mul_raw.expo = xe + we;
      mul_raw.sig  = {12'b0, 16'(xm * wm)};
      mul_spec      = 1'b1;
      mul_spec_bits = '0;
      if (xnan || wnan || (xinf && wzero) || (winf && xzero)) begin
         mul_spec_bits = FP32_QNAN;
      end else if (xinf || winf) begin
         mul_spec_bits = {mul_raw.sign, FP32_INF[30:0]};
      end else if (xzero || wzero) begin
         mul_spec_bits = '0;
      end else begin
         mul_spec = 1'b0;
      end
   end

   // fp32 add: swap, align with sticky, add or subtract
   always_comb begin
      logic [31:0] big, sml;
      logic [7:0]  eb, es, d;
      logic [23:0] mb, ms;
      logic [26:0] a_al, b_al;
      logic [53:0] ext;
      logic        anan, bnan, ainf, binf;
      anan = (acc_ff[30:23] == 8'hFF) && (acc_ff[22:0] != '0);
      bnan = (prod_ff[30:23] == 8'hFF) && (prod_ff[22:0] != '0);
      ainf = (acc_ff[30:23] == 8'hFF) && (acc_ff[22:0] == '0);
      binf = (prod_ff[30:23] == 8'hFF) && (prod_ff[22:0] == '0);
      if (prod_ff[30:0] > acc_ff[30:0]) begin
         big = prod_ff;
         sml = acc_ff;
      end else begin
         big = acc_ff;
         sml = prod_ff;
      end
      eb   = (big[30:23] == '0) ? 8'd1 : big[30:23];
      es   = (sml[30:23] == '0) ? 8'd1 : sml[30:23];
      mb   = {big[30:23] != '0, big[22:0]};
      ms   = {sml[30:23] != '0, sml[22:0]};
      d    = eb - es;
      a_al = {mb, 3'b0};
      ext  = '0;
      if (d >= 8'd27) begin
         b_al = {26'b0, ms != '0};
      end else begin
         ext  = {ms, 3'b0, 27'b0} >> d;
         b_al = ext[53:27];
         b_al[0] = b_al[0] | (|ext[26:0]);
      end
      add_raw.sign = big[31];
      add_raw.expo = $signed({3'b0, eb}) - 11'sd153;
      add_raw.sig  = (big[31] == sml[31]) ? ({1'b0, a_al} + {1'b0, b_al})
                                          : ({1'b0, a_al} - {1'b0, b_al});
      add_spec      = 1'b1;
      add_spec_bits = '0;
      if (anan || bnan || (ainf && binf && (acc_ff[31] != prod_ff[31]))) begin
         add_spec_bits = FP32_QNAN;
      end else if (ainf) begin
         add_spec_bits = acc_ff;
      end else if (binf) begin
         add_spec_bits = prod_ff;
      end else begin
         add_spec = 1'b0;
      end
   end

   // shared round and pack, used for the product and for the sum
   assign pack_out = round_pack(raw_ff);

   // relu and bf16 rounding of the finished sum
   always_comb begin
      logic [31:0] rounded;
      logic        positive;
      positive = !acc_ff[31] && (acc_ff[30:0] != '0) &&
                 !((acc_ff[30:23] == 8'hFF) && (acc_ff[22:0] != '0));
      rounded  = acc_ff + 32'h0000_7FFF + 32'(acc_ff[16]);
      relu_value = positive ? rounded[31:16] : 16'h0000;
   end

   // sequencer
   always_comb begin
      logic [2:0] s;
      state_in     = state_ff;
      y_in         = y_ff;
      x_in         = x_ff;
      c_in         = c_ff;
      slot_in      = slot_ff;
      top_row_in   = top_row_ff;
      left_col_in  = left_col_ff;
      top_slot_in  = top_slot_ff;
      image_end_in = image_end_ff;
      oc_in        = oc_ff;
      ky_in        = ky_ff;
      kx_in        = kx_ff;
      ic_in        = ic_ff;
      w_addr_in    = w_addr_ff;
      raw_in       = raw_ff;
      spec_in      = spec_ff;
      spec_bits_in = spec_bits_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_value_in = rsp_value_ff;
      rsp_oc_in    = rsp_oc_ff;
      rsp_lastp_in = rsp_lastp_ff;
      rsp_lasti_in = rsp_lasti_ff;
      s            = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire && (req_tuser == ACT_PIXEL)) begin
               if (c_ff == CW'(IN_CHANNELS - 1)) begin
                  c_in = '0;
                  if ((y_ff[0] || (y_ff == YW'(IMAGE_HEIGHT - 1))) &&
                      (x_ff[0] || (x_ff == XW'(IMAGE_WIDTH - 1)))) begin
                     top_row_in   = YS'({2'b0, y_ff}) - (y_ff[0] ? YS'(2) : YS'(1));
                     left_col_in  = XS'({2'b0, x_ff}) - (x_ff[0] ? XS'(2) : XS'(1));
                     s            = {1'b0, slot_ff} + (y_ff[0] ? 3'd1 : 3'd2);
                     top_slot_in  = (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
                     image_end_in = (y_ff == YW'(IMAGE_HEIGHT - 1)) &&
                                    (x_ff == XW'(IMAGE_WIDTH - 1));
                     oc_in        = '0;
                     ky_in        = '0;
                     kx_in        = '0;
                     ic_in        = '0;
                     w_addr_in    = '0;
                     acc_in       = '0;
                     state_in     = S_FETCH;
                  end
                  if (x_ff == XW'(IMAGE_WIDTH - 1)) begin
                     x_in = '0;
                     if (y_ff == YW'(IMAGE_HEIGHT - 1)) begin
                        y_in    = '0;
                        slot_in = '0;
                     end else begin
                        y_in    = y_ff + 1'b1;
                        slot_in = (slot_ff == 2'd2) ? 2'd0 : slot_ff + 2'd1;
                     end
                  end else begin
                     x_in = x_ff + 1'b1;
                  end
               end else begin
                  c_in = c_ff + 1'b1;
               end
            end
         end
         S_FETCH: begin
            if (tap_pad) begin
               state_in = S_FETCH;
            end else begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            raw_in       = mul_raw;
            spec_in      = mul_spec;
            spec_bits_in = mul_spec_bits;
            state_in     = S_PACKM;
         end
         S_PACKM: begin
            prod_in  = spec_ff ? spec_bits_ff : pack_out;
            state_in = S_ADD;
         end
         S_ADD: begin
            raw_in       = add_raw;
            spec_in      = add_spec;
            spec_bits_in = add_spec_bits;
            state_in     = S_PACKA;
         end
         S_PACKA: begin
            acc_in = spec_ff ? spec_bits_ff : pack_out;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = relu_value;
               rsp_oc_in    = 2'(oc_ff);
               rsp_lastp_in = (oc_ff == OW'(OUT_CHANNELS - 1));
               rsp_lasti_in = (oc_ff == OW'(OUT_CHANNELS - 1)) && image_end_ff;
               if (oc_ff == OW'(OUT_CHANNELS - 1)) begin
                  state_in = S_IDLE;
               end else begin
                  oc_in    = oc_ff + 1'b1;
                  ky_in    = '0;
                  kx_in    = '0;
                  ic_in    = '0;
                  acc_in   = '0;
                  state_in = S_FETCH;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // step to the next tap after a padded fetch or a finished accumulate
      if (((state_ff == S_FETCH) && tap_pad) || (state_ff == S_PACKA)) begin
         w_addr_in = w_addr_ff + 1'b1;
         if (ic_ff == CW'(IN_CHANNELS - 1)) begin
            ic_in = '0;
            if (kx_ff == 2'd2) begin
               kx_in = '0;
               ky_in = ky_ff + 2'd1;
            end else begin
               kx_in = kx_ff + 2'd1;
            end
         end else begin
            ic_in = ic_ff + 1'b1;
         end
         state_in = tap_last ? S_OUT : S_FETCH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         y_ff         <= '0;
         x_ff         <= '0;
         c_ff         <= '0;
         slot_ff      <= '0;
         oc_ff        <= '0;
         ky_ff        <= '0;
         kx_ff        <= '0;
         ic_ff        <= '0;
         w_addr_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         y_ff         <= y_in;
         x_ff         <= x_in;
         c_ff         <= c_in;
         slot_ff      <= slot_in;
         oc_ff        <= oc_in;
         ky_ff        <= ky_in;
         kx_ff        <= kx_in;
         ic_ff        <= ic_in;
         w_addr_ff    <= w_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      top_row_ff   <= top_row_in;
      left_col_ff  <= left_col_in;
      top_slot_ff  <= top_slot_in;
      image_end_ff <= image_end_in;
      raw_ff       <= raw_in;
      spec_ff      <= spec_in;
      spec_bits_ff <= spec_bits_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      rsp_value_ff <= rsp_value_in;
      rsp_oc_ff    <= rsp_oc_in;
      rsp_lastp_ff <= rsp_lastp_in;
      rsp_lasti_ff <= rsp_lasti_in;
   end

   // weight store
   always_ff @(posedge clock) begin
      if (req_fire && (req_tuser == ACT_WEIGHT) && (int'(req_index) < W_DEPTH)) begin
         weight_mem[WA_W'(req_index)] <= req_sample;
      end
      if (state_ff == S_FETCH) begin
         w_rd_ff <= weight_mem[w_addr_ff];
      end
   end

   // three-row ring
   always_ff @(posedge clock) begin
      if (req_fire && (req_tuser == ACT_PIXEL)) begin
         ring_mem[ring_wr_addr] <= req_sample;
      end
      if (state_ff == S_FETCH) begin
         x_rd_ff <= ring_mem[ring_rd_addr];
      end
   end

endmodule

// ===== verif/tb_conv3x3_stride2_relu_bf16_top.sv =====
// self-checking testbench for the 3x3 stride-2 relu convolution on bf16 data
// depends on c3s2r_pkg and conv3x3_stride2_relu_bf16_top; carries its own
// bit-accurate predictor of the fp32 accumulation and bf16 rounding
`timescale 1ns / 1ps

module tb_conv3x3_stride2_relu_bf16_top;
   import c3s2r_pkg::*;

   localparam int H      = DEF_IMAGE_HEIGHT;
   localparam int W      = DEF_IMAGE_WIDTH;
   localparam int OC     = DEF_OUT_CHANNELS;
   localparam int NW     = OC * TAPS;
   localparam int RING_N = 3 * W;
   localparam int IDLE_LIMIT = 20000;

   typedef struct {
      logic        action;
      logic [5:0]  index;
      logic [15:0] sample;
      bit          drain;
   } beat_type;

   typedef struct {
      logic [15:0] value;
      logic [1:0]  chan;
      logic        last_px;
      logic        last_img;
   } conv_out_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tuser;

   beat_type     pending_q[$];
   conv_out_type expected_q[$];
   logic [15:0] weights[NW];
   logic [15:0] ring[RING_N];
   int          row_pos = 0;
   int          col_pos = 0;
   int          errors = 0;
   int          results_seen = 0;
   int          idle_cycles = 0;
   logic        req_hit = 1'b0;
   logic        rsp_hit = 1'b0;
   int          send_gap = 0;
   int          recv_gap = 0;
   int          long_hold = 0;
   bit          hold_done = 0;

   conv3x3_stride2_relu_bf16_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // fp32 bits to real, exact
   function automatic real f32_to_real(input logic [31:0] f);
      logic [10:0] e;
      real         tiny;
      tiny = $bitstoreal({1'b0, 11'(1023 - 149), 52'b0});
      if (f[30:23] == 8'hFF) begin
         e = 11'h7FF;
      end else if (f[30:23] == 8'h00) begin
         return (f[31] ? -1.0 : 1.0) * real'(f[22:0]) * tiny;
      end else begin
         e = 11'(f[30:23]) + 11'd896;
      end
      return $bitstoreal({f[31], e, f[22:0], 29'b0});
   endfunction

   // real to fp32 bits, round to nearest even with subnormals and overflow
   function automatic logic [31:0] real_to_f32(input real r);
      logic [63:0] d;
      logic [63:0] sig;
      logic [63:0] q;
      logic [63:0] rem;
      logic [63:0] half;
      logic [63:0] total;
      int          ex;
      int          sh;
      d = $realtobits(r);
      if (d[62:52] == 11'h7FF) return {d[63], 8'hFF, (d[51:0] != 0) ? 23'h400000 : 23'h0};
      if (d[62:52] == 11'h000) return {d[63], 31'b0};
      ex  = int'(d[62:52]) - 1023;
      sig = {11'b0, 1'b1, d[51:0]};
      if (ex > 127) return {d[63], 8'hFF, 23'h0};
      sh = (ex >= -126) ? 29 : 29 + (-126 - ex);
      if (sh > 60) sh = 60;
      q    = sig >> sh;
      rem  = sig - (q << sh);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q = q + 1;
      total = (ex >= -126) ? ((64'(ex + 126) << 23) + q) : q;
      if (total >= 64'h7F80_0000) return {d[63], 8'hFF, 23'h0};
      return {d[63], total[30:0]};
   endfunction

   function automatic logic [15:0] output_pixel(input int oc, input int oy, input int ox);
      real         acc;
      real         prod;
      int          iy;
      int          ix;
      logic [31:0] u;
      acc = 0.0;
      for (int ky = 0; ky < 3; ky++) begin
         for (int kx = 0; kx < 3; kx++) begin
            iy = 2 * oy + ky - 1;
            ix = 2 * ox + kx - 1;
            if (iy >= 0 && iy < H && ix >= 0 && ix < W) begin
               prod = f32_to_real({ring[(iy % 3) * W + ix], 16'b0})
                    * f32_to_real({weights[oc * TAPS + ky * 3 + kx], 16'b0});
               prod = f32_to_real(real_to_f32(prod));
               acc  = f32_to_real(real_to_f32(acc + prod));
            end
         end
      end
      if (!(acc > 0.0)) return 16'h0000;
      u = real_to_f32(acc);
      u = u + 32'h7FFF + 32'(u[16]);
      return u[31:16];
   endfunction

   task automatic predict_beat(input logic action, input logic [5:0] index,
                               input logic [15:0] sample);
      conv_out_type r;
      bit           last_img;
      if (action == ACT_WEIGHT) begin
         if (index < NW) weights[index] = sample;
         return;
      end
      ring[(row_pos % 3) * W + col_pos] = sample;
      last_img = (row_pos == H - 1) && (col_pos == W - 1);
      if ((row_pos[0] || row_pos == H - 1) && (col_pos[0] || col_pos == W - 1)) begin
         for (int oc = 0; oc < OC; oc++) begin
            r.value    = output_pixel(oc, row_pos >> 1, col_pos >> 1);
            r.chan     = 2'(oc);
            r.last_px  = (oc == OC - 1);
            r.last_img = (oc == OC - 1) && last_img;
            expected_q.push_back(r);
         end
      end
      if (col_pos == W - 1) begin
         col_pos = 0;
         row_pos = (row_pos == H - 1) ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
   endtask

   function automatic logic [15:0] rand_bf16();
      if ($urandom_range(0, 15) == 0) return 16'($urandom);
      return {1'($urandom), 8'($urandom_range(118, 136)), 7'($urandom)};
   endfunction

   function automatic int draw_gap();
      if (((results_seen / 32) % 2) == 1) return 0;
      return $urandom_range(0, 11);
   endfunction

   task automatic add_beat(input logic action, input logic [5:0] index,
                           input logic [15:0] sample, input bit drain);
      beat_type b;
      b.action = action;
      b.index  = index;
      b.sample = sample;
      b.drain  = drain;
      pending_q.push_back(b);
   endtask

   // monitor, predictor feed and watchdog
   always @(posedge clock) begin
      conv_out_type e;
      req_hit <= req_tvalid && req_tready;
      rsp_hit <= rsp_tvalid && rsp_tready;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (req_tvalid && req_tready) begin
            predict_beat(req_tuser, req_tdata[5:0], req_tdata[21:6]);
         end
         if (rsp_tvalid && rsp_tready) begin
            results_seen <= results_seen + 1;
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected beat, actual %h last %b user %b",
                        $time, rsp_tdata, rsp_tlast, rsp_tuser);
               errors <= errors + 1;
            end else begin
               e = expected_q.pop_front();
               if (rsp_tdata[15:0] !== e.value || rsp_tdata[17:16] !== e.chan
                   || rsp_tdata[23:18] !== 6'b0 || rsp_tlast !== e.last_px
                   || rsp_tuser !== e.last_img) begin
                  $display("%0t: mismatch, expected value %h chan %0d last %b user %b,",
                           $time, e.value, e.chan, e.last_px, e.last_img);
                  $display("   actual data %h last %b user %b",
                           rsp_tdata, rsp_tlast, rsp_tuser);
                  errors <= errors + 1;
               end
            end
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // sender
   always @(negedge clock) begin
      beat_type b;
      if (!reset && !(req_tvalid && !req_hit)) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_q.size() > 0
                      && !(pending_q[0].drain && expected_q.size() != 0)) begin
            b = pending_q.pop_front();
            req_tuser  <= b.action;
            req_tdata  <= {2'b0, b.sample, b.index};
            req_tvalid <= 1'b1;
            send_gap   <= draw_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_hit) recv_gap = draw_gap();
         if (!hold_done && results_seen >= 40) begin
            long_hold = 3000;
            hold_done = 1;
         end
         if (long_hold > 0) begin
            long_hold = long_hold - 1;
            rsp_tready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap = recv_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int px;
      // ignored slots beyond the store
      add_beat(ACT_WEIGHT, 6'd36, 16'hFFFF, 0);
      add_beat(ACT_WEIGHT, 6'd63, 16'hFFFF, 0);
      for (int i = 0; i < NW; i++) add_beat(ACT_WEIGHT, 6'(i), rand_bf16() & 16'h7FFF, 0);
      // center taps: overflow, minus infinity, nan, subnormal
      add_beat(ACT_WEIGHT, 6'd4, 16'h7F7F, 0);
      add_beat(ACT_WEIGHT, 6'd13, 16'hFF80, 0);
      add_beat(ACT_WEIGHT, 6'd22, 16'h7FC1, 0);
      add_beat(ACT_WEIGHT, 6'd31, 16'h0001, 0);
      add_beat(ACT_PIXEL, 6'd0, 16'h7F7F, 0);
      add_beat(ACT_PIXEL, 6'd0, 16'h0000, 0);
      add_beat(ACT_PIXEL, 6'd0, 16'h8000, 0);
      add_beat(ACT_PIXEL, 6'd0, 16'hFFFF, 0);
      px = 4;
      while (px < 160) begin
         if (px == 32) begin
            add_beat(ACT_WEIGHT, 6'd4, rand_bf16(), 0);
            add_beat(ACT_WEIGHT, 6'd13, rand_bf16(), 0);
            add_beat(ACT_WEIGHT, 6'd22, 16'h3F80, 0);
         end
         if ($urandom_range(0, 11) == 0) begin
            add_beat(ACT_WEIGHT, 6'($urandom_range(0, 63)),
                     ($urandom_range(0, 19) == 0) ? 16'($urandom)
                        : {1'($urandom), 8'($urandom_range(118, 136)), 7'($urandom)}, 0);
         end else begin
            add_beat(ACT_PIXEL, 6'($urandom), rand_bf16(), px == 100);
            px++;
         end
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      wait (pending_q.size() == 0 && !req_tvalid);
      wait (expected_q.size() == 0);
      repeat (400) @(posedge clock);
      if (errors == 0 && expected_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/c3s2r_pkg.sv
hdl/conv3x3_stride2_relu_bf16_top.sv
verif/tb_conv3x3_stride2_relu_bf16_top.sv
